FILE: hdl/fmh_pkg.sv
package fmh_pkg;

  // Task identifier width, fixed by the request format
  localparam int TASK_W = 5;

  // Waiter queue geometry
  localparam int QDEPTH = 32;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Stream widths (tdata padded to whole bytes)
  localparam int IN_TDATA_W  = ((TASK_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 4 + TASK_W + 1 + TASK_W + 6;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_LOCK   = 2'd0,
    REQ_TRY    = 2'd1,
    REQ_UNLOCK = 2'd2
  } req_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // One result transaction
  typedef struct packed {
    logic [5:0]        waiting_count;
    logic [TASK_W-1:0] owner_task;
    logic              owner_valid;
    logic [TASK_W-1:0] wake_id;
    logic              wake_valid;
    logic              overflow;
    logic              must_block;
    logic              granted;
  } result_t;

  // Advance a queue pointer with wrap
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(QDEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

FILE: hdl/fmh_ram.sv
module fmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fifo_mutex_handoff.sv
// Hardware mutex with a FIFO of waiting tasks and direct ownership handoff.
// Input stream: in_tuser carries the request kind (lock, try, unlock),
// in_tdata the task id. Output stream: one result transaction per request
// with grant/block/overflow flags, the woken task on a handoff, the owner
// after the request and the number of queued waiters.
// out_tvalid rises once the accepted request has passed the EXEC state,
// which waits until the output register is free or drains in that cycle.
// The block takes no new request until the current one has executed. The
// queue head is read from the waiter memory (a registered read) in the accept
// cycle and the read-modify-write of owner, pointers and memory happens in EXEC.
// Reset: mutex free, queue empty, no result pending. The waiter memory is
// not cleared; an entry is used only after it has been written.
// Receiver stall: the result waits in the output register; one further
// request is accepted and held until the output register frees up.
module fifo_mutex_handoff (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fmh_pkg::IN_TDATA_W-1:0] in_tdata,  // [4:0] task_id, rest zero
  input  logic [1:0]                     in_tuser,  // [1:0] req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] granted, [1] must_block, [2] overflow, [3] wake_valid,
  // [8:4] wake_id, [9] owner_valid, [14:10] owner_task,
  // [20:15] waiting_count, rest zero
  output logic [fmh_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int TW = fmh_pkg::TASK_W;

  fmh_pkg::state_t state_r, state_nxt;

  // Accepted request
  fmh_pkg::req_t   req_type_r;
  logic [TW-1:0]   task_r;

  // Mutex and queue control
  logic                      held_r, held_nxt;
  logic [TW-1:0]             holder_r, holder_nxt;
  logic [fmh_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [fmh_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [fmh_pkg::CNT_W-1:0] count_r, count_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  fmh_pkg::result_t res_r, res_nxt;

  // Memory port
  logic          mem_we;
  logic [TW-1:0] mem_rdata;
  logic          in_fire;
  logic          exec_fire;

  assign in_tready = (state_r == fmh_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == fmh_pkg::S_EXEC) && (!out_valid_r || out_tready);

  // Head is always fetched at accept; used only by an unlock with waiters
  fmh_ram #(
    .WIDTH (TW),
    .DEPTH (fmh_pkg::QDEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r),
    .wdata (task_r),
    .re    (in_fire),
    .raddr (head_r),
    .rdata (mem_rdata)
  );

  // Request execution
  always_comb begin
    held_nxt   = held_r;
    holder_nxt = holder_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    res_nxt    = '0;

    case (req_type_r)
      fmh_pkg::REQ_LOCK: begin
        if (!held_r) begin
          held_nxt        = 1'b1;
          holder_nxt      = task_r;
          res_nxt.granted = 1'b1;
        end else if (holder_r == task_r) begin
          res_nxt.granted = 1'b1;
        end else if (count_r >= fmh_pkg::CNT_W'(fmh_pkg::QDEPTH)) begin
          res_nxt.overflow = 1'b1;
        end else begin
          mem_we             = exec_fire;
          tail_nxt           = fmh_pkg::next_slot(tail_r);
          count_nxt          = count_r + 1'b1;
          res_nxt.must_block = 1'b1;
        end
      end
      fmh_pkg::REQ_TRY: begin
        if (!held_r) begin
          held_nxt        = 1'b1;
          holder_nxt      = task_r;
          res_nxt.granted = 1'b1;
        end else if (holder_r == task_r) begin
          res_nxt.granted = 1'b1;
        end
      end
      fmh_pkg::REQ_UNLOCK: begin
        if (held_r) begin
          if (count_r != '0) begin
            // hand off to the oldest waiter
            head_nxt           = fmh_pkg::next_slot(head_r);
            count_nxt          = count_r - 1'b1;
            holder_nxt         = mem_rdata;
            res_nxt.wake_valid = 1'b1;
            res_nxt.wake_id    = mem_rdata;
          end else begin
            held_nxt   = 1'b0;
            holder_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase

    res_nxt.owner_valid   = held_nxt;
    res_nxt.owner_task    = held_nxt ? holder_nxt : '0;
    res_nxt.waiting_count = 6'(count_nxt);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      fmh_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = fmh_pkg::S_EXEC;
        end
      end
      fmh_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_nxt     = fmh_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = fmh_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmh_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= 1'b0;
      holder_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        held_r   <= held_nxt;
        holder_r <= holder_nxt;
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r <= fmh_pkg::req_t'(in_tuser);
      task_r     <= in_tdata[TW-1:0];
    end
    if (exec_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = fmh_pkg::OUT_TDATA_W'(res_r);

endmodule

FILE: hdl/fmh_checker.sv
module fmh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fmh_pkg::OUT_TDATA_W-1:0] out_tdata
);

  fmh_pkg::result_t res;
  assign res = fmh_pkg::result_t'(out_tdata[$bits(fmh_pkg::result_t)-1:0]);

  // A stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another executes");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A handoff makes the woken task the owner
  a_handoff_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.wake_valid |->
      res.owner_valid && (res.owner_task == res.wake_id))
    else $error("woken task is not the owner");

  // A grant leaves the mutex held; a block leaves a waiter queued
  a_grant_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.granted || res.must_block) |->
      res.owner_valid && (!res.must_block || (res.waiting_count != '0)))
    else $error("grant or block inconsistent with state");

endmodule

bind fifo_mutex_handoff fmh_checker u_fmh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
